### rtl/core/c2s_pkg.sv
// Shared constants, widths and the arctangent table for the Cartesian to
// spherical converter. No dependencies.
package c2s_pkg;

    // coordinate format: two's complement, 16 fraction bits
    localparam int COORD_W = 32;
    // extra fraction bits carried by the horizontal length into the elevation path
    localparam int RXY_PAD = 16;
    localparam int RXY_W   = COORD_W + RXY_PAD;

    // binary angle width, 2^ANGLE_W units per full turn
    localparam int ANGLE_W = 32;

    // vectoring unit sizing
    localparam int CORDIC_STAGES_DEF = 32;
    localparam int ATAN_TAB_LEN      = 48;
    localparam int NORM_W            = 60;
    localparam int NORM_STEPS        = 6;
    localparam int CORDIC_W          = 64;

    // fixed angle codes
    localparam logic [ANGLE_W-1:0] ANG_ZERO     = 32'h0000_0000;
    localparam logic [ANGLE_W-1:0] ANG_POS_HALF = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] ANG_NEG_PI   = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] ANG_NEG_HALF = 32'hC000_0000;

    // atan(2^-i) in binary angle units, rounded
    localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0
    };

endpackage

### rtl/core/c2s_in_if.sv
// Input channel: one Cartesian vector per item with valid/ready handshake.
// Depends on c2s_pkg.
interface c2s_in_if;
    import c2s_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    output ready);
endinterface

### rtl/core/c2s_out_if.sv
// Output channel: one spherical result per item with valid/ready handshake.
// Depends on c2s_pkg.
interface c2s_out_if;
    import c2s_pkg::*;

    logic                      valid;
    logic                      ready;
    logic        [COORD_W-1:0] radius;
    logic signed [ANGLE_W-1:0] azimuth_angle;
    logic signed [ANGLE_W-1:0] elevation_angle;
    logic                      zero_vector;

    modport source (output valid, output radius, output azimuth_angle,
                    output elevation_angle, output zero_vector, input ready);
    modport sink   (input valid, input radius, input azimuth_angle,
                    input elevation_angle, input zero_vector, output ready);
endinterface

### rtl/core/c2s_delay.sv
// Stall-aware delay line for payload that waits on the longer paths.
// Depends on nothing.
module c2s_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    // shift one place per advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

### rtl/core/c2s_isqrt.sv
// Pipelined floor square root, one root bit per stage, with remainder.
// Depends on nothing.
module c2s_isqrt #(
    parameter int RAD_W = 64
) (
    input  logic               clk,
    input  logic               en,
    input  logic [RAD_W-1:0]   radicand,
    output logic [RAD_W/2-1:0] root,
    output logic [RAD_W/2:0]   rem
);
    localparam int RW = RAD_W / 2;

    logic [RAD_W-1:0] rad_reg [RW];
    logic [RW-1:0]    rt_reg  [RW];
    logic [RW:0]      rm_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [RAD_W-1:0] rad_cur;
        logic [RW-1:0]    rt_cur;
        logic [RW:0]      rm_cur;
        logic [RW+2:0]    trial;
        logic [RW+2:0]    sub_val;
        logic [RW+2:0]    diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rad_cur = radicand;
            assign rt_cur  = '0;
            assign rm_cur  = '0;
        end
        else
        begin : g_next
            assign rad_cur = rad_reg[k-1];
            assign rt_cur  = rt_reg[k-1];
            assign rm_cur  = rm_reg[k-1];
        end

        // bring down two radicand bits and try root*4+1
        assign trial   = {rm_cur, rad_cur[RAD_W-1 -: 2]};
        assign sub_val = {1'b0, rt_cur, 2'b01};
        assign ge      = (trial >= sub_val);
        assign diff    = trial - sub_val;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k] <= rad_cur << 2;
                rt_reg[k]  <= {rt_cur[RW-2:0], ge};
                rm_reg[k]  <= ge ? diff[RW:0] : trial[RW:0];
            end
        end
    end

    assign root = rt_reg[RW-1];
    assign rem  = rm_reg[RW-1];
endmodule

### rtl/core/c2s_vec_angle.sv
// Binary angle of a vector given as sign and magnitude: pipelined normalizer,
// quadrant fold and CORDIC vectoring, one stage per iteration. Depends on c2s_pkg.
module c2s_vec_angle #(
    parameter int MAG_W  = 32,
    parameter int STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        a_neg,
    input  logic [MAG_W-1:0]            a_mag,
    input  logic                        b_neg,
    input  logic [MAG_W-1:0]            b_mag,
    output logic [c2s_pkg::ANGLE_W-1:0] angle
);
    import c2s_pkg::*;

    typedef struct packed {
        logic               a_neg;
        logic               b_neg;
        logic               special;
        logic [ANGLE_W-1:0] sp_angle;
    } side_t;

    logic [NORM_W-1:0]          na_reg [NORM_STEPS];
    logic [NORM_W-1:0]          nb_reg [NORM_STEPS];
    side_t                      ns_reg [NORM_STEPS];
    logic signed [CORDIC_W-1:0] ca_reg [STAGES+1];
    logic signed [CORDIC_W-1:0] cb_reg [STAGES+1];
    logic [ANGLE_W-1:0]         acc_reg [STAGES+1];
    side_t                      cs_reg [STAGES+1];

    side_t                      side_in;
    logic signed [CORDIC_W-1:0] am_full;
    logic signed [CORDIC_W-1:0] bm_full;
    logic signed [CORDIC_W-1:0] a_fold;
    logic signed [CORDIC_W-1:0] b_fold;
    logic [ANGLE_W-1:0]         acc_fold;

    // on an axis or at the origin the angle is exact
    always_comb
    begin
        side_in.a_neg   = a_neg;
        side_in.b_neg   = b_neg;
        side_in.special = (a_mag == '0) || (b_mag == '0);
        priority if ((a_mag == '0) && (b_mag == '0))
            side_in.sp_angle = ANG_ZERO;
        else if (b_mag == '0)
            side_in.sp_angle = a_neg ? ANG_NEG_PI : ANG_ZERO;
        else
            side_in.sp_angle = b_neg ? ANG_NEG_HALF : ANG_POS_HALF;
    end

    // normalize so the larger magnitude has its top bit at NORM_W-1
    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - k);
        logic [NORM_W-1:0] a_cur;
        logic [NORM_W-1:0] b_cur;
        logic [NORM_W-1:0] or_cur;
        side_t             s_cur;
        logic              do_shift;

        if (k == 0)
        begin : g_first
            assign a_cur = NORM_W'(a_mag);
            assign b_cur = NORM_W'(b_mag);
            assign s_cur = side_in;
        end
        else
        begin : g_next
            assign a_cur = na_reg[k-1];
            assign b_cur = nb_reg[k-1];
            assign s_cur = ns_reg[k-1];
        end

        assign or_cur   = a_cur | b_cur;
        assign do_shift = (or_cur[NORM_W-1 -: SH] == '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                na_reg[k] <= do_shift ? (a_cur << SH) : a_cur;
                nb_reg[k] <= do_shift ? (b_cur << SH) : b_cur;
                ns_reg[k] <= s_cur;
            end
        end
    end

    // fold the left half plane into the right one
    assign am_full = CORDIC_W'(na_reg[NORM_STEPS-1]);
    assign bm_full = CORDIC_W'(nb_reg[NORM_STEPS-1]);

    always_comb
    begin
        if (ns_reg[NORM_STEPS-1].a_neg)
        begin
            a_fold   = bm_full;
            b_fold   = ns_reg[NORM_STEPS-1].b_neg ? -am_full : am_full;
            acc_fold = ns_reg[NORM_STEPS-1].b_neg ? ANG_NEG_HALF : ANG_POS_HALF;
        end
        else
        begin
            a_fold   = am_full;
            b_fold   = ns_reg[NORM_STEPS-1].b_neg ? -bm_full : bm_full;
            acc_fold = ANG_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg[0]  <= a_fold;
            cb_reg[0]  <= b_fold;
            acc_reg[0] <= acc_fold;
            cs_reg[0]  <= ns_reg[NORM_STEPS-1];
        end
    end

    // vectoring iterations drive b toward zero
    for (genvar i = 0; i < STAGES; i++)
    begin : g_cordic
        logic signed [CORDIC_W-1:0] da;
        logic signed [CORDIC_W-1:0] db;

        assign da = ca_reg[i] >>> i;
        assign db = cb_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cb_reg[i][CORDIC_W-1])
                begin
                    ca_reg[i+1]  <= ca_reg[i] + db;
                    cb_reg[i+1]  <= cb_reg[i] - da;
                    acc_reg[i+1] <= acc_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    ca_reg[i+1]  <= ca_reg[i] - db;
                    cb_reg[i+1]  <= cb_reg[i] + da;
                    acc_reg[i+1] <= acc_reg[i] - ATAN_TAB[i];
                end
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    assign angle = cs_reg[STAGES].special ? cs_reg[STAGES].sp_angle : acc_reg[STAGES];
endmodule

### rtl/core/cartesian_to_spherical_top.sv
// Cartesian to spherical converter, fully pipelined with a global stall.
// Throughput: one item per cycle unless the output item is held; the depth is set
// by the 48-stage square root of the horizontal length followed by the elevation
// normalizer and CORDIC.
// Reset clears the valid bits only; no clearing pass, items are taken at once.
// Depends on c2s_pkg, c2s_in_if, c2s_out_if, c2s_delay, c2s_isqrt, c2s_vec_angle.
module cartesian_to_spherical_top #(
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    c2s_in_if.sink   vec_in,
    c2s_out_if.source sph_out
);
    import c2s_pkg::*;

    localparam int SQ_W     = 2 * COORD_W;
    localparam int VA_LAT   = NORM_STEPS + 1 + CORDIC_STAGES;
    localparam int EL_END   = 3 + RXY_W + VA_LAT;
    localparam int PIPE_LEN = EL_END + 1;
    localparam int Z_DLY    = RXY_W + 2;
    localparam int AZ_DLY   = EL_END - (1 + VA_LAT);
    localparam int R_DLY    = EL_END - (3 + COORD_W);
    localparam int ZF_DLY   = EL_END - 1;

    logic                en;
    logic [PIPE_LEN-1:0] vld_reg;

    logic [COORD_W-1:0]  xu, yu, zu;
    logic [COORD_W-1:0]  xm_reg, ym_reg, zm_reg;
    logic                xn_reg, yn_reg, zn_reg, zero_reg;
    logic [SQ_W-1:0]     xsq_reg, ysq_reg, zsq_reg;
    logic [SQ_W-1:0]     sxy_reg, sum_reg;

    logic [COORD_W-1:0]  root_r;
    logic [COORD_W:0]    rem_r;
    logic [COORD_W-1:0]  radius_rnd;
    logic [COORD_W-1:0]  radius_d;
    logic [RXY_W-1:0]    rxy;
    logic [RXY_W:0]      rxy_rem;
    logic [COORD_W-1:0]  zm_d;
    logic                zn_d;
    logic [ANGLE_W-1:0]  az_raw, az_d;
    logic [ANGLE_W-1:0]  el_raw, el_clamp;
    logic                zero_d;

    logic [COORD_W-1:0]  radius_reg;
    logic [ANGLE_W-1:0]  az_reg;
    logic [ANGLE_W-1:0]  el_reg;
    logic                zflag_reg;

    // the whole pipeline advances unless the output item is held
    assign en           = !vld_reg[PIPE_LEN-1] || sph_out.ready;
    assign vec_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], vec_in.valid};
        end
    end

    // sign and magnitude of each component
    assign xu = vec_in.x_coord;
    assign yu = vec_in.y_coord;
    assign zu = vec_in.z_coord;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn_reg   <= xu[COORD_W-1];
            yn_reg   <= yu[COORD_W-1];
            zn_reg   <= zu[COORD_W-1];
            xm_reg   <= xu[COORD_W-1] ? (~xu + 1'b1) : xu;
            ym_reg   <= yu[COORD_W-1] ? (~yu + 1'b1) : yu;
            zm_reg   <= zu[COORD_W-1] ? (~zu + 1'b1) : zu;
            zero_reg <= (xu == '0) && (yu == '0) && (zu == '0);
        end
    end

    // squares, then the horizontal and full sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xsq_reg <= SQ_W'(xm_reg) * SQ_W'(xm_reg);
            ysq_reg <= SQ_W'(ym_reg) * SQ_W'(ym_reg);
            zsq_reg <= SQ_W'(zm_reg) * SQ_W'(zm_reg);
            sxy_reg <= xsq_reg + ysq_reg;
            sum_reg <= xsq_reg + ysq_reg + zsq_reg;
        end
    end

    // radius: floor root, then round half up from the remainder
    c2s_isqrt #(.RAD_W(SQ_W)) u_root_len (
        .clk      (clk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root_r),
        .rem      (rem_r)
    );

    assign radius_rnd = root_r + COORD_W'(rem_r > {1'b0, root_r});

    c2s_delay #(.WIDTH(COORD_W), .DEPTH(R_DLY)) u_dly_radius (
        .clk (clk),
        .en  (en),
        .d   (radius_rnd),
        .q   (radius_d)
    );

    // horizontal length with extra fraction bits
    c2s_isqrt #(.RAD_W(2 * RXY_W)) u_root_xy (
        .clk      (clk),
        .en       (en),
        .radicand ({sxy_reg, (2 * RXY_W - SQ_W)'(0)}),
        .root     (rxy),
        .rem      (rxy_rem)
    );

    // z waits for the horizontal length
    c2s_delay #(.WIDTH(COORD_W + 1), .DEPTH(Z_DLY)) u_dly_z (
        .clk (clk),
        .en  (en),
        .d   ({zn_reg, zm_reg}),
        .q   ({zn_d, zm_d})
    );

    // azimuth from x and y
    c2s_vec_angle #(.MAG_W(COORD_W), .STAGES(CORDIC_STAGES)) u_azimuth (
        .clk   (clk),
        .en    (en),
        .a_neg (xn_reg),
        .a_mag (xm_reg),
        .b_neg (yn_reg),
        .b_mag (ym_reg),
        .angle (az_raw)
    );

    c2s_delay #(.WIDTH(ANGLE_W), .DEPTH(AZ_DLY)) u_dly_az (
        .clk (clk),
        .en  (en),
        .d   (az_raw),
        .q   (az_d)
    );

    // elevation from horizontal length and z
    c2s_vec_angle #(.MAG_W(RXY_W), .STAGES(CORDIC_STAGES)) u_elevation (
        .clk   (clk),
        .en    (en),
        .a_neg (1'b0),
        .a_mag (rxy),
        .b_neg (zn_d),
        .b_mag ({zm_d, RXY_PAD'(0)}),
        .angle (el_raw)
    );

    c2s_delay #(.WIDTH(1), .DEPTH(ZF_DLY)) u_dly_zero (
        .clk (clk),
        .en  (en),
        .d   (zero_reg),
        .q   (zero_d)
    );

    // keep the elevation within a quarter turn either way
    always_comb
    begin
        priority if ((el_raw > ANG_POS_HALF) && (el_raw < ANG_NEG_PI))
            el_clamp = ANG_POS_HALF;
        else if ((el_raw >= ANG_NEG_PI) && (el_raw < ANG_NEG_HALF))
            el_clamp = ANG_NEG_HALF;
        else
            el_clamp = el_raw;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            radius_reg <= radius_d;
            az_reg     <= az_d;
            el_reg     <= el_clamp;
            zflag_reg  <= zero_d;
        end
    end

    assign sph_out.valid           = vld_reg[PIPE_LEN-1];
    assign sph_out.radius          = radius_reg;
    assign sph_out.azimuth_angle   = az_reg;
    assign sph_out.elevation_angle = el_reg;
    assign sph_out.zero_vector     = zflag_reg;
endmodule
